// File: src/pcbc_pkg.sv
// Shared types and constants for the point cloud box crop filter.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package pcbc_pkg;

   localparam int COORD_W = 32;
   localparam int QUAT_W = 16;
   localparam int ENTRY_W = 18;
   localparam int MAT_FRAC = 16;
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = ENTRY_W + DIFF_W;
   localparam int SUM_W = PROD_W + 2;
   localparam int QPROD_W = 2 * QUAT_W;
   localparam int QACC_W = QPROD_W + 4;
   localparam int ROUND_SHIFT = 12;
   localparam int ADDR_W = 6;
   localparam int DATA_W = 64;

   localparam logic [2:0] REG_QUAT = 3'd0;
   localparam logic [2:0] REG_ORIGIN_X = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
   localparam logic [2:0] REG_ORIGIN_Z = 3'd3;
   localparam logic [2:0] REG_BOUND_X_LOW = 3'd4;
   localparam logic [2:0] REG_BOUND_X_HIGH = 3'd5;
   localparam logic [2:0] REG_BOUND_Y_LOW = 3'd6;
   localparam logic [2:0] REG_BOUND_Y_HIGH = 3'd7;

   localparam logic [DATA_W-1:0] QUAT_RESET = 64'h4000_0000_0000_0000;
   localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 18'sd131071;
   localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = -18'sd131072;
   localparam logic signed [ENTRY_W-1:0] ENTRY_ONE = 18'sd65536;
   localparam logic signed [QACC_W-1:0] QUAT_ONE = 36'sd268435456;
   localparam logic signed [QACC_W-1:0] ROUND_HALF = 36'sd2048;

   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef entry_type [8:0] matrix_type;

   typedef struct packed {
      logic [DATA_W-1:0] quaternion;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] bound_x_low;
      logic signed [COORD_W-1:0] bound_x_high;
      logic signed [COORD_W-1:0] bound_y_low;
      logic signed [COORD_W-1:0] bound_y_high;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
      logic depth_invalid;
      logic odd_position;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] kept_x;
      logic signed [COORD_W-1:0] kept_y;
      logic signed [COORD_W-1:0] kept_z;
   } rsp_payload_type;

endpackage

`default_nettype wire

// File: src/pcbc_if.sv
// Valid/ready stream interfaces for the point input and the kept point output.
// Depends on pcbc_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface pcbc_req_if;
   import pcbc_pkg::*;
   logic valid;
   logic ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pcbc_rsp_if;
   import pcbc_pkg::*;
   logic valid;
   logic ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/pcbc_csr.sv
// APB-style register file holding the quaternion, plane origin and crop bounds.
// Depends on pcbc_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps
`default_nettype none

module pcbc_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [pcbc_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [pcbc_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [pcbc_pkg::DATA_W-1:0] csr_prdata,
   output logic                             csr_pready,
   output pcbc_pkg::cfg_type                cfg,
   output logic      [pcbc_pkg::DATA_W-1:0] next_quaternion
);
   import pcbc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [2:0] index;
   logic wr_en;

   assign index = csr_paddr[ADDR_W-1:3];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;
   assign next_quaternion = cfg_in.quaternion;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_QUAT:         cfg_in.quaternion = csr_pwdata;
            REG_ORIGIN_X:     cfg_in.origin_x = csr_pwdata[COORD_W-1:0];
            REG_ORIGIN_Y:     cfg_in.origin_y = csr_pwdata[COORD_W-1:0];
            REG_ORIGIN_Z:     cfg_in.origin_z = csr_pwdata[COORD_W-1:0];
            REG_BOUND_X_LOW:  cfg_in.bound_x_low = csr_pwdata[COORD_W-1:0];
            REG_BOUND_X_HIGH: cfg_in.bound_x_high = csr_pwdata[COORD_W-1:0];
            REG_BOUND_Y_LOW:  cfg_in.bound_y_low = csr_pwdata[COORD_W-1:0];
            REG_BOUND_Y_HIGH: cfg_in.bound_y_high = csr_pwdata[COORD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_QUAT:         csr_prdata = cfg_ff.quaternion;
         REG_ORIGIN_X:     csr_prdata = {32'd0, cfg_ff.origin_x};
         REG_ORIGIN_Y:     csr_prdata = {32'd0, cfg_ff.origin_y};
         REG_ORIGIN_Z:     csr_prdata = {32'd0, cfg_ff.origin_z};
         REG_BOUND_X_LOW:  csr_prdata = {32'd0, cfg_ff.bound_x_low};
         REG_BOUND_X_HIGH: csr_prdata = {32'd0, cfg_ff.bound_x_high};
         REG_BOUND_Y_LOW:  csr_prdata = {32'd0, cfg_ff.bound_y_low};
         REG_BOUND_Y_HIGH: csr_prdata = {32'd0, cfg_ff.bound_y_high};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quaternion <= QUAT_RESET;
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.origin_z <= '0;
         cfg_ff.bound_x_low <= 32'sh8000_0000;
         cfg_ff.bound_x_high <= 32'sh7FFF_FFFF;
         cfg_ff.bound_y_low <= 32'sh8000_0000;
         cfg_ff.bound_y_high <= 32'sh7FFF_FFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: src/pcbc_matrix.sv
// Two-stage unit that turns the configured quaternion into the rotation matrix.
// Depends on pcbc_pkg for widths, rounding constants and the matrix type.
`timescale 1ns / 1ps
`default_nettype none

module pcbc_matrix (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [pcbc_pkg::DATA_W-1:0] quaternion,
   output pcbc_pkg::matrix_type             matrix
);
   import pcbc_pkg::*;

   typedef logic signed [QPROD_W-1:0] qprod_type;

   logic signed [QUAT_W-1:0] qx, qy, qz, qw;
   qprod_type xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   qprod_type xx_in, yy_in, zz_in, xy_in, xz_in, yz_in, wx_in, wy_in, wz_in;
   matrix_type matrix_ff;
   matrix_type matrix_in;

   function automatic logic signed [QACC_W-1:0] ext(input qprod_type p);
      return {{(QACC_W - QPROD_W){p[QPROD_W-1]}}, p};
   endfunction

   function automatic entry_type to_entry(input logic signed [QACC_W-1:0] a);
      logic signed [QACC_W-1:0] b;
      logic signed [QACC_W-ROUND_SHIFT-1:0] r;
      b = a + ROUND_HALF;
      r = b[QACC_W-1:ROUND_SHIFT];
      if (r > $signed({{(QACC_W - ROUND_SHIFT - ENTRY_W){1'b0}}, ENTRY_MAX})) begin
         return ENTRY_MAX;
      end else if (r < $signed({{(QACC_W - ROUND_SHIFT - ENTRY_W){1'b1}}, ENTRY_MIN})) begin
         return ENTRY_MIN;
      end
      return r[ENTRY_W-1:0];
   endfunction

   assign qx = quaternion[15:0];
   assign qy = quaternion[31:16];
   assign qz = quaternion[47:32];
   assign qw = quaternion[63:48];

   always_comb begin
      xx_in = qx * qx;
      yy_in = qy * qy;
      zz_in = qz * qz;
      xy_in = qx * qy;
      xz_in = qx * qz;
      yz_in = qy * qz;
      wx_in = qw * qx;
      wy_in = qw * qy;
      wz_in = qw * qz;
   end

   always_comb begin
      matrix_in[0] = to_entry(QUAT_ONE - ((ext(yy_ff) + ext(zz_ff)) <<< 1));
      matrix_in[1] = to_entry((ext(xy_ff) - ext(wz_ff)) <<< 1);
      matrix_in[2] = to_entry((ext(xz_ff) + ext(wy_ff)) <<< 1);
      matrix_in[3] = to_entry((ext(xy_ff) + ext(wz_ff)) <<< 1);
      matrix_in[4] = to_entry(QUAT_ONE - ((ext(xx_ff) + ext(zz_ff)) <<< 1));
      matrix_in[5] = to_entry((ext(yz_ff) - ext(wx_ff)) <<< 1);
      matrix_in[6] = to_entry((ext(xz_ff) - ext(wy_ff)) <<< 1);
      matrix_in[7] = to_entry((ext(yz_ff) + ext(wx_ff)) <<< 1);
      matrix_in[8] = to_entry(QUAT_ONE - ((ext(xx_ff) + ext(yy_ff)) <<< 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xx_ff <= '0;
         yy_ff <= '0;
         zz_ff <= '0;
         xy_ff <= '0;
         xz_ff <= '0;
         yz_ff <= '0;
         wx_ff <= '0;
         wy_ff <= '0;
         wz_ff <= '0;
         matrix_ff <= {ENTRY_ONE, {3{entry_type'(0)}}, ENTRY_ONE,
                       {3{entry_type'(0)}}, ENTRY_ONE};
      end else begin
         xx_ff <= xx_in;
         yy_ff <= yy_in;
         zz_ff <= zz_in;
         xy_ff <= xy_in;
         xz_ff <= xz_in;
         yz_ff <= yz_in;
         wx_ff <= wx_in;
         wy_ff <= wy_in;
         wz_ff <= wz_in;
         matrix_ff <= matrix_in;
      end
   end

   assign matrix = matrix_ff;

endmodule

`default_nettype wire

// File: src/pcbc_datapath.sv
// Four-stage point pipeline: origin subtract, products, sums, box test and output.
// Depends on pcbc_pkg and the stream interfaces in pcbc_if.
`timescale 1ns / 1ps
`default_nettype none

module pcbc_datapath #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  pcbc_pkg::cfg_type         cfg,
   input  pcbc_pkg::matrix_type      matrix,
   pcbc_req_if.sink                  req_stream,
   pcbc_rsp_if.source                rsp_stream
);
   import pcbc_pkg::*;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   localparam logic signed [63:0] ZMinWide = (64'sd1 <<< (FRACTION_BITS + MAT_FRAC)) / 64'sd200;
   localparam logic signed [SUM_W-1:0] ZMin = ZMinWide[SUM_W-1:0];

   logic advance;
   logic keep;

   logic s1_valid_ff;
   rsp_payload_type s1_point_ff;
   diff_type [2:0] s1_diff_ff;

   logic s2_valid_ff;
   rsp_payload_type s2_point_ff;
   prod_type [8:0] s2_prod_ff;
   prod_type [8:0] s2_prod_in;

   logic s3_valid_ff;
   rsp_payload_type s3_point_ff;
   sum_type [2:0] s3_sum_ff;
   sum_type [2:0] s3_sum_in;

   logic out_valid_ff;
   rsp_payload_type out_point_ff;
   logic pass;

   function automatic sum_type scaled(input logic signed [COORD_W-1:0] b);
      return {{(SUM_W - COORD_W - MAT_FRAC){b[COORD_W-1]}}, b, {MAT_FRAC{1'b0}}};
   endfunction

   function automatic sum_type ext_prod(input prod_type p);
      return {{(SUM_W - PROD_W){p[PROD_W-1]}}, p};
   endfunction

   assign advance = !out_valid_ff || rsp_stream.ready;
   assign req_stream.ready = advance;
   assign keep = req_stream.valid && !req_stream.payload.depth_invalid
                 && !req_stream.payload.odd_position;

   always_comb begin
      for (int col = 0; col < 3; col++) begin
         for (int row = 0; row < 3; row++) begin
            s2_prod_in[3 * col + row] = $signed(matrix[3 * row + col]) * s1_diff_ff[row];
         end
      end
   end

   always_comb begin
      for (int col = 0; col < 3; col++) begin
         s3_sum_in[col] = ext_prod(s2_prod_ff[3 * col]) + ext_prod(s2_prod_ff[3 * col + 1])
                          + ext_prod(s2_prod_ff[3 * col + 2]);
      end
   end

   assign pass = (s3_sum_ff[0] > scaled(cfg.bound_x_low))
                 && (s3_sum_ff[0] < scaled(cfg.bound_x_high))
                 && (s3_sum_ff[1] > scaled(cfg.bound_y_low))
                 && (s3_sum_ff[1] < scaled(cfg.bound_y_high))
                 && (s3_sum_ff[2] > ZMin);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= keep;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff && pass;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_point_ff.kept_x <= req_stream.payload.point_x;
         s1_point_ff.kept_y <= req_stream.payload.point_y;
         s1_point_ff.kept_z <= req_stream.payload.point_z;
         s1_diff_ff[0] <= diff_type'(req_stream.payload.point_x) - diff_type'(cfg.origin_x);
         s1_diff_ff[1] <= diff_type'(req_stream.payload.point_y) - diff_type'(cfg.origin_y);
         s1_diff_ff[2] <= diff_type'(req_stream.payload.point_z) - diff_type'(cfg.origin_z);
         s2_point_ff <= s1_point_ff;
         s2_prod_ff <= s2_prod_in;
         s3_point_ff <= s2_point_ff;
         s3_sum_ff <= s3_sum_in;
         out_point_ff <= s3_point_ff;
      end
   end

   assign rsp_stream.valid = out_valid_ff;
   assign rsp_stream.payload = out_point_ff;

endmodule

`default_nettype wire

// File: src/point_cloud_box_crop_filter.sv
// Box crop filter: a kept point goes through diff, product, sum and output registers.
// Throughput is one beat per cycle; the four-stage point pipeline stalls as a whole
// only while the output register holds a beat that is not taken.
// The quaternion-to-matrix unit starts on the write beat and registers the products and
// then the new matrix, before any point accepted after the write multiplies by it.
// Synchronous active-high reset empties the pipeline and restores the reset registers.
// Depends on pcbc_pkg, pcbc_if, pcbc_csr, pcbc_matrix and pcbc_datapath.
`timescale 1ns / 1ps
`default_nettype none

module point_cloud_box_crop_filter #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   pcbc_req_if.sink                         req_stream,
   pcbc_rsp_if.source                       rsp_stream,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [pcbc_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [pcbc_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [pcbc_pkg::DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import pcbc_pkg::*;

   cfg_type cfg;
   matrix_type matrix;
   logic [DATA_W-1:0] next_quaternion;

   pcbc_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready),
      .cfg             (cfg),
      .next_quaternion (next_quaternion)
   );

   pcbc_matrix u_matrix (
      .clock      (clock),
      .reset      (reset),
      .quaternion (next_quaternion),
      .matrix     (matrix)
   );

   pcbc_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .matrix     (matrix),
      .req_stream (req_stream),
      .rsp_stream (rsp_stream)
   );

endmodule

`default_nettype wire

// File: test/point_cloud_box_crop_filter_tb.sv
// Self-checking testbench for the point cloud box crop filter: a directed table and random
// phases of points, predicted in the bench and compared beat by beat on the kept stream.
// Depends on pcbc_pkg, pcbc_if and the point_cloud_box_crop_filter top level.
`timescale 1ns / 1ps

module point_cloud_box_crop_filter_tb;
   import pcbc_pkg::*;

   localparam int LATENCY = 4;
   localparam int DRAIN_LIMIT = 2000;
   localparam int PHASES = 8;
   localparam int PHASE_POINTS = 200;
   localparam int DIRECTED_ROWS = 43;
   localparam logic [31:0] COORD_MIN = 32'h8000_0000;
   localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam longint Z_FLOOR = (longint'(1) << 32) / 200;

   typedef enum logic [1:0] {ROW_POINT, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {CHECK_MODEL, CHECK_KEEP, CHECK_DROP} check_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0] index;
      logic [63:0] value;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic invalid;
      logic odd;
      check_type check;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic csr_pready;

   pcbc_req_if req_if ();
   pcbc_rsp_if rsp_if ();

   point_cloud_box_crop_filter i_dut (
      .clock(clock),
      .reset(reset),
      .req_stream(req_if),
      .rsp_stream(rsp_if),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   cfg_type crop_cfg;
   matrix_type crop_matrix;
   rsp_payload_type kept_points_due[$];
   rsp_payload_type due_point;
   int error_count = 0;
   bit steady = 1'b0;

   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{ROW_POINT, REG_QUAT, 64'd0, 32'd0, 32'd0, 32'd328, 1'b0, 1'b0, CHECK_KEEP},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'd0, 32'd0, 32'd327, 1'b0, 1'b0, CHECK_DROP},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'd0, 32'd0, COORD_MAX, 1'b0, 1'b0, CHECK_KEEP},
      '{ROW_POINT, REG_QUAT, 64'd0, COORD_MIN, 32'd0, 32'h1_0000, 1'b0, 1'b0, CHECK_DROP},
      '{ROW_POINT, REG_QUAT, 64'd0, COORD_MAX, 32'd0, 32'h1_0000, 1'b0, 1'b0, CHECK_DROP},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'h8000_0001, 32'h7FFF_FFFE, COORD_MAX, 1'b0, 1'b0,
        CHECK_KEEP},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'd0, COORD_MIN, 32'h1_0000, 1'b0, 1'b0, CHECK_DROP},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'd0, 32'd0, 32'h1_0000, 1'b1, 1'b0, CHECK_DROP},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'd0, 32'd0, 32'h1_0000, 1'b0, 1'b1, CHECK_DROP},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'd0, 32'd0, 32'h1_0000, 1'b1, 1'b1, CHECK_DROP},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0,
        CHECK_DROP},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'd0, 32'd0, COORD_MIN, 1'b0, 1'b0, CHECK_DROP},
      '{ROW_WRITE, REG_QUAT, 64'h2D41_2D41_0000_0000, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_WRITE, REG_ORIGIN_X, 64'h0000_8000, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, CHECK_MODEL},
      '{ROW_WRITE, REG_ORIGIN_Y, 64'hFFFF_8000, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, CHECK_MODEL},
      '{ROW_WRITE, REG_ORIGIN_Z, 64'hFFFF_0000, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, CHECK_MODEL},
      '{ROW_WRITE, REG_BOUND_X_LOW, 64'hFFFF_0000, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_WRITE, REG_BOUND_X_HIGH, 64'h0001_0000, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_WRITE, REG_BOUND_Y_LOW, 64'hFFFE_0000, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_WRITE, REG_BOUND_Y_HIGH, 64'h0002_0000, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'h1_0000, 32'h8000, 32'd0, 1'b0, 1'b0, CHECK_MODEL},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'h8000, 32'h1_8000, 32'h1_0000, 1'b0, 1'b0, CHECK_MODEL},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'h2_8000, 32'd0, 32'h8000, 1'b0, 1'b0, CHECK_MODEL},
      '{ROW_WRITE, REG_BOUND_X_LOW, 64'h0001_0000, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_WRITE, REG_BOUND_X_HIGH, 64'hFFFF_0000, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'd0, 32'd0, 32'h1_0000, 1'b0, 1'b0, CHECK_DROP},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'h8000, 32'h8000, 32'h2_0000, 1'b0, 1'b0, CHECK_DROP},
      '{ROW_WRITE, REG_BOUND_X_LOW, {32'd0, COORD_MIN}, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_WRITE, REG_BOUND_X_HIGH, {32'd0, COORD_MAX}, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_WRITE, REG_QUAT, 64'h7FFF_7FFF_7FFF_7FFF, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'h1_0000, 32'h2_0000, 32'h3_0000, 1'b0, 1'b0, CHECK_MODEL},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'hFFFF_0000, 32'h1_0000, 32'hFFFD_0000, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_WRITE, REG_QUAT, 64'h8000_8000_8000_8000, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 1'b0, 1'b0, CHECK_MODEL},
      '{ROW_WRITE, REG_QUAT, QUAT_RESET, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, CHECK_MODEL},
      '{ROW_WRITE, REG_ORIGIN_X, {32'd0, COORD_MIN}, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_WRITE, REG_ORIGIN_Y, {32'd0, COORD_MAX}, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_WRITE, REG_ORIGIN_Z, {32'd0, COORD_MIN}, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_WRITE, REG_BOUND_Y_LOW, {32'd0, COORD_MIN}, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_WRITE, REG_BOUND_Y_HIGH, {32'd0, COORD_MAX}, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0,
        CHECK_MODEL},
      '{ROW_POINT, REG_QUAT, 64'd0, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0, 1'b0, CHECK_MODEL},
      '{ROW_POINT, REG_QUAT, 64'd0, COORD_MIN, COORD_MAX, COORD_MIN, 1'b0, 1'b0, CHECK_MODEL},
      '{ROW_POINT, REG_QUAT, 64'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, CHECK_MODEL}
   };

   function automatic entry_type round_entry(longint exact);
      longint rounded;
      rounded = (exact + 2048) >>> 12;
      if (rounded > 131071) rounded = 131071;
      if (rounded < -131072) rounded = -131072;
      return entry_type'(rounded);
   endfunction

   function automatic matrix_type rotation_from_quat(logic [63:0] quat);
      longint qx, qy, qz, qw, one;
      matrix_type m;
      qx = longint'($signed(quat[15:0]));
      qy = longint'($signed(quat[31:16]));
      qz = longint'($signed(quat[47:32]));
      qw = longint'($signed(quat[63:48]));
      one = longint'(1) << 28;
      m[0] = round_entry(one - 2 * (qy * qy + qz * qz));
      m[1] = round_entry(2 * (qx * qy - qw * qz));
      m[2] = round_entry(2 * (qx * qz + qw * qy));
      m[3] = round_entry(2 * (qx * qy + qw * qz));
      m[4] = round_entry(one - 2 * (qx * qx + qz * qz));
      m[5] = round_entry(2 * (qy * qz - qw * qx));
      m[6] = round_entry(2 * (qx * qz - qw * qy));
      m[7] = round_entry(2 * (qy * qz + qw * qx));
      m[8] = round_entry(one - 2 * (qx * qx + qy * qy));
      return m;
   endfunction

   function automatic longint entry_at(int k);
      return longint'($signed(crop_matrix[k]));
   endfunction

   function automatic bit point_in_box(req_payload_type p);
      longint tx, ty, tz, rx, ry, rz;
      if (p.depth_invalid || p.odd_position) return 1'b0;
      tx = longint'($signed(p.point_x)) - longint'($signed(crop_cfg.origin_x));
      ty = longint'($signed(p.point_y)) - longint'($signed(crop_cfg.origin_y));
      tz = longint'($signed(p.point_z)) - longint'($signed(crop_cfg.origin_z));
      rx = entry_at(0) * tx + entry_at(3) * ty + entry_at(6) * tz;
      ry = entry_at(1) * tx + entry_at(4) * ty + entry_at(7) * tz;
      rz = entry_at(2) * tx + entry_at(5) * ty + entry_at(8) * tz;
      return rx > (longint'($signed(crop_cfg.bound_x_low)) <<< MAT_FRAC)
         && rx < (longint'($signed(crop_cfg.bound_x_high)) <<< MAT_FRAC)
         && ry > (longint'($signed(crop_cfg.bound_y_low)) <<< MAT_FRAC)
         && ry < (longint'($signed(crop_cfg.bound_y_high)) <<< MAT_FRAC)
         && rz > Z_FLOOR;
   endfunction

   function automatic rsp_payload_type kept_copy(req_payload_type p);
      rsp_payload_type k;
      k.kept_x = p.point_x;
      k.kept_y = p.point_y;
      k.kept_z = p.point_z;
      return k;
   endfunction

   function automatic void note_error(string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
   endfunction

   function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         note_error($sformatf("%s expected %h, got %h", name, want, got));
   endfunction

   always @(negedge clock) rsp_if.ready <= steady || ($urandom_range(0, 99) >= 20);

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (kept_points_due.size() == 0) begin
            note_error($sformatf("kept point %h with none due", rsp_if.payload));
         end else begin
            due_point = kept_points_due.pop_front();
            check_field("kept_x", rsp_if.payload.kept_x, due_point.kept_x);
            check_field("kept_y", rsp_if.payload.kept_y, due_point.kept_y);
            check_field("kept_z", rsp_if.payload.kept_z, due_point.kept_z);
         end
      end
   end

   task automatic csr_access(input bit is_write, input logic [2:0] index,
                             input logic [63:0] value, output logic [63:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= ADDR_W'({index, 3'b000});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic write_and_check(input logic [2:0] index, input logic [63:0] value);
      logic [63:0] rdata;
      csr_access(1'b1, index, value, rdata);
      case (index)
         REG_QUAT: begin
            crop_cfg.quaternion = value;
            crop_matrix = rotation_from_quat(value);
         end
         REG_ORIGIN_X: crop_cfg.origin_x = value[31:0];
         REG_ORIGIN_Y: crop_cfg.origin_y = value[31:0];
         REG_ORIGIN_Z: crop_cfg.origin_z = value[31:0];
         REG_BOUND_X_LOW: crop_cfg.bound_x_low = value[31:0];
         REG_BOUND_X_HIGH: crop_cfg.bound_x_high = value[31:0];
         REG_BOUND_Y_LOW: crop_cfg.bound_y_low = value[31:0];
         REG_BOUND_Y_HIGH: crop_cfg.bound_y_high = value[31:0];
         default: ;
      endcase
      csr_access(1'b0, index, 64'd0, rdata);
      if (index == REG_QUAT ? rdata !== value : rdata[31:0] !== value[31:0])
         note_error($sformatf("register %0d read %h, written %h", index, rdata, value));
   endtask

   task automatic send_point(input req_payload_type p, input check_type check);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 20) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= p;
      do @(posedge clock); while (!req_if.ready);
      if (check == CHECK_KEEP || (check == CHECK_MODEL && point_in_box(p)))
         kept_points_due = {kept_points_due, kept_copy(p)};
   endtask

   task automatic wait_for_kept_points();
      int waited;
      waited = 0;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (kept_points_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (kept_points_due.size() != 0) begin
         note_error($sformatf("%0d kept points never came", kept_points_due.size()));
         kept_points_due.delete();
      end
   endtask

   task automatic quiesce();
      wait_for_kept_points();
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   function automatic int near_offset(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic logic [63:0] random_unit_quat();
      real c [4];
      real norm;
      logic [63:0] quat;
      norm = 0.0;
      for (int k = 0; k < 4; k++) begin
         c[k] = real'(int'($urandom_range(0, 32768)) - 16384);
         norm = norm + c[k] * c[k];
      end
      if (norm < 1.0) return QUAT_RESET;
      norm = $sqrt(norm);
      for (int k = 0; k < 4; k++) quat[16*k +: 16] = 16'($rtoi(c[k] / norm * 16384.0));
      return quat;
   endfunction

   function automatic req_payload_type random_point();
      req_payload_type p;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         p.point_x = crop_cfg.origin_x + near_offset(4 * 65536);
         p.point_y = crop_cfg.origin_y + near_offset(4 * 65536);
         p.point_z = crop_cfg.origin_z + near_offset(4 * 65536);
      end else if (pick < 85) begin
         p.point_x = crop_cfg.origin_x + near_offset(1)
            + (pick[0] ? crop_cfg.bound_x_low : crop_cfg.bound_x_high);
         p.point_y = crop_cfg.origin_y + near_offset(1)
            + ($urandom_range(0, 1) ? crop_cfg.bound_y_low : crop_cfg.bound_y_high);
         p.point_z = crop_cfg.origin_z + 328 + near_offset(1);
      end else begin
         p.point_x = $urandom;
         p.point_y = $urandom;
         p.point_z = $urandom;
      end
      p.depth_invalid = ($urandom_range(0, 3) == 0);
      p.odd_position = ($urandom_range(0, 3) == 0);
      return p;
   endfunction

   task automatic write_random_setting(input int phase);
      logic [63:0] quat;
      logic [31:0] low_x, high_x, low_y, high_y, swap;
      case (phase % 4)
         1: quat = QUAT_RESET;
         3: quat = {$urandom, $urandom};
         default: quat = random_unit_quat();
      endcase
      write_and_check(REG_QUAT, quat);
      write_and_check(REG_ORIGIN_X, phase == 6 ? $urandom : near_offset(2 * 65536));
      write_and_check(REG_ORIGIN_Y, phase == 6 ? $urandom : near_offset(2 * 65536));
      write_and_check(REG_ORIGIN_Z, phase == 6 ? $urandom : near_offset(2 * 65536));
      if (phase == 1 || phase == 7) begin
         low_x = COORD_MIN;
         high_x = COORD_MAX;
         low_y = COORD_MIN;
         high_y = COORD_MAX;
      end else begin
         low_x = -int'($urandom_range(0, 3 * 65536));
         high_x = int'($urandom_range(0, 3 * 65536));
         low_y = -int'($urandom_range(0, 3 * 65536));
         high_y = int'($urandom_range(0, 3 * 65536));
      end
      if (phase == 4) begin
         swap = low_x;
         low_x = high_x;
         high_x = swap;
      end
      write_and_check(REG_BOUND_X_LOW, low_x);
      write_and_check(REG_BOUND_X_HIGH, high_x);
      write_and_check(REG_BOUND_Y_LOW, low_y);
      write_and_check(REG_BOUND_Y_HIGH, high_y);
   endtask

   initial begin
      req_payload_type p;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      crop_cfg = '{QUAT_RESET, 32'd0, 32'd0, 32'd0, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX};
      crop_matrix = rotation_from_quat(QUAT_RESET);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            quiesce();
            write_and_check(directed_rows[r].index, directed_rows[r].value);
         end else begin
            p.point_x = directed_rows[r].x;
            p.point_y = directed_rows[r].y;
            p.point_z = directed_rows[r].z;
            p.depth_invalid = directed_rows[r].invalid;
            p.odd_position = directed_rows[r].odd;
            send_point(p, directed_rows[r].check);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         quiesce();
         write_random_setting(phase);
         steady = (phase == 2);
         for (int n = 0; n < PHASE_POINTS; n++) begin
            if (phase == 3 && n == PHASE_POINTS / 2) wait_for_kept_points();
            send_point(random_point(), CHECK_MODEL);
         end
      end
      steady = 1'b0;

      wait_for_kept_points();
      repeat (4 * LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// File: point_cloud_box_crop_filter.f
src/pcbc_pkg.sv
src/pcbc_if.sv
src/pcbc_csr.sv
src/pcbc_matrix.sv
src/pcbc_datapath.sv
src/point_cloud_box_crop_filter.sv
test/point_cloud_box_crop_filter_tb.sv
